[src/ibrsf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ibrsf_pkg;
	localparam int NUM_SENSORS = 4;
	localparam int SIDX_W = 2;
	localparam int GRAV_W = 22;
	localparam logic [GRAV_W-1:0] GRAV_RESET = 22'd642908;
	localparam logic signed [20:0] USEC_PER_SEC = 21'sd1000000;
	localparam int PER_W = 20;
	// dividend of the rate division: |dv| * 1e6 + period / 2
	localparam int DIV_W = 53;
	localparam int DIV_CNT_W = 6;

	function automatic logic signed [31:0] sat40(input logic signed [39:0] x);
		logic signed [31:0] r;
		if (x > 40'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

[src/imu_body_rate_and_specific_force_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Inertial sensor emulator. One sample is taken when in_valid is high and in_stall low. The
// block then works on it and shows one result on out_valid until it is transferred. The next
// sample can be taken in the cycle after that transfer. The time is set by one shared 34x21
// multiplier (ten quaternion products, three velocity scalings and thirty-six partial
// products of the two body-frame rotations) and by a one-bit-per-cycle divider that runs
// once for each acceleration component when differencing is active. The gravity register
// may be written at any time the block is idle; there is no clearing pass after reset.
module imu_body_rate_and_specific_force_top (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_wr_en,
	input  wire         [21:0] cfg_wr_data,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire          [1:0] sensor_index,
	input  wire signed  [15:0] quat_w,
	input  wire signed  [15:0] quat_x,
	input  wire signed  [15:0] quat_y,
	input  wire signed  [15:0] quat_z,
	input  wire signed  [31:0] ang_vel_world_x,
	input  wire signed  [31:0] ang_vel_world_y,
	input  wire signed  [31:0] ang_vel_world_z,
	input  wire signed  [31:0] lin_vel_world_x,
	input  wire signed  [31:0] lin_vel_world_y,
	input  wire signed  [31:0] lin_vel_world_z,
	input  wire         [19:0] period_us,
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [15:0] orient_x,
	output logic signed [15:0] orient_y,
	output logic signed [15:0] orient_z,
	output logic signed [15:0] orient_w,
	output logic signed [31:0] body_rate_x,
	output logic signed [31:0] body_rate_y,
	output logic signed [31:0] body_rate_z,
	output logic signed [31:0] specific_force_x,
	output logic signed [31:0] specific_force_y,
	output logic signed [31:0] specific_force_z
);
	import ibrsf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_QMUL, ST_MAT, ST_AMUL, ST_AGO, ST_AWAIT, ST_UPD,
		ST_DOT, ST_DRAIN, ST_RND, ST_OUT
	} state_t;

	state_t               state_q;
	logic [3:0]           cnt_q;
	logic [1:0]           comp_q;
	logic [2:0]           out_q;
	logic [2:0]           term_q;
	logic                 en_q;
	logic                 mv_q;
	logic                 mh_q;
	logic                 neg_q;
	logic [GRAV_W-1:0]    grav_q;

	logic [SIDX_W-1:0]    idx_q;
	logic signed [15:0]   qw_q, qx_q, qy_q, qz_q;
	logic signed [31:0]   ang_q [3];
	logic signed [31:0]   lin_q [3];
	logic [PER_W-1:0]     per_q;
	logic signed [31:0]   prev_q [NUM_SENSORS][3];
	logic                 have_q [NUM_SENSORS];
	logic signed [31:0]   p_q [10];
	logic signed [31:0]   r_q [3][3];
	logic signed [31:0]   acc_q [3];
	logic signed [31:0]   res_q [6];
	logic signed [54:0]   mul_q;
	logic signed [67:0]   dacc_q;

	logic signed [33:0]   mul_a;
	logic signed [20:0]   mul_b;
	logic signed [54:0]   prod;
	logic signed [15:0]   qa, qb;
	logic signed [32:0]   diff;
	logic [32:0]          mag;
	logic [1:0]           ti;
	logic [1:0]           kc;
	logic signed [31:0]   coef;
	logic signed [32:0]   vec;
	logic signed [67:0]   term;
	logic signed [67:0]   rnd;
	logic                 div_start;
	logic                 div_done;
	logic [DIV_W-1:0]     div_quo;
	logic [DIV_W-1:0]     div_num;
	logic signed [31:0]   acc_res;

	always_comb begin
		case (cnt_q)
			4'd0: begin qa = qw_q; qb = qw_q; end
			4'd1: begin qa = qx_q; qb = qx_q; end
			4'd2: begin qa = qy_q; qb = qy_q; end
			4'd3: begin qa = qz_q; qb = qz_q; end
			4'd4: begin qa = qx_q; qb = qy_q; end
			4'd5: begin qa = qw_q; qb = qz_q; end
			4'd6: begin qa = qx_q; qb = qz_q; end
			4'd7: begin qa = qw_q; qb = qy_q; end
			4'd8: begin qa = qy_q; qb = qz_q; end
			default: begin qa = qw_q; qb = qx_q; end
		endcase
	end

	always_comb begin
		diff = {lin_q[comp_q][31], lin_q[comp_q]} - {prev_q[idx_q][comp_q][31],
			prev_q[idx_q][comp_q]};
		mag  = diff[32] ? 33'(-diff) : 33'(diff);
		ti   = term_q[2:1];
		kc   = (out_q < 3'd3) ? out_q[1:0] : 2'(out_q - 3'd3);
		coef = r_q[ti][kc];
		if (out_q < 3'd3) begin
			vec = {ang_q[ti][31], ang_q[ti]};
		end else if (ti == 2'd2) begin
			vec = {acc_q[2][31], acc_q[2]} + {11'b0, grav_q};
		end else begin
			vec = {acc_q[ti][31], acc_q[ti]};
		end
	end

	// shared multiplier operand selection
	always_comb begin
		case (state_q)
			ST_QMUL: begin
				mul_a = {{18{qa[15]}}, qa};
				mul_b = {{5{qb[15]}}, qb};
			end
			ST_AMUL: begin
				mul_a = {1'b0, mag};
				mul_b = USEC_PER_SEC;
			end
			default: begin
				mul_a = {{2{coef[31]}}, coef};
				// high half is floor(v / 2^16), low half the unsigned rest
				mul_b = term_q[0] ? {5'b0, vec[15:0]} : {{4{vec[32]}}, vec[32:16]};
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign term = mh_q ? ({{13{mul_q[54]}}, mul_q} <<< 16) : {{13{mul_q[54]}}, mul_q};
	assign rnd  = dacc_q + 68'sd134217728;

	assign div_start = (state_q == ST_AGO);
	assign div_num   = mul_q[DIV_W-1:0] + DIV_W'(per_q >> 1);

	always_comb begin
		if (!neg_q) begin
			acc_res = (div_quo > DIV_W'(32'h7fffffff)) ? 32'sh7fffffff : div_quo[31:0];
		end else begin
			acc_res = (div_quo > DIV_W'(33'h080000000)) ? 32'sh80000000
				: 32'(-div_quo[31:0]);
		end
	end

	ibrsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (per_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
			out_q   <= '0;
			term_q  <= '0;
			mv_q    <= 1'b0;
			grav_q  <= GRAV_RESET;
			for (int s = 0; s < NUM_SENSORS; s++) begin
				have_q[s] <= 1'b0;
				for (int c = 0; c < 3; c++) prev_q[s][c] <= '0;
			end
		end else begin
			if (cfg_wr_en) grav_q <= cfg_wr_data;
			mv_q <= (state_q == ST_DOT);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= ST_QMUL;
					end
				end
				ST_QMUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd9) state_q <= ST_MAT;
				end
				ST_MAT: begin
					comp_q  <= '0;
					state_q <= ST_AMUL;
				end
				ST_AMUL: begin
					if (en_q) begin
						state_q <= ST_AGO;
					end else if (comp_q == 2'd2) begin
						state_q <= ST_UPD;
					end else begin
						comp_q <= comp_q + 1'b1;
					end
				end
				ST_AGO: state_q <= ST_AWAIT;
				ST_AWAIT: begin
					if (div_done) begin
						if (comp_q == 2'd2) begin
							state_q <= ST_UPD;
						end else begin
							comp_q  <= comp_q + 1'b1;
							state_q <= ST_AMUL;
						end
					end
				end
				ST_UPD: begin
					if (32'(idx_q) < NUM_SENSORS) begin
						have_q[idx_q] <= 1'b1;
						for (int c = 0; c < 3; c++) prev_q[idx_q][c] <= lin_q[c];
					end
					out_q   <= '0;
					term_q  <= '0;
					state_q <= ST_DOT;
				end
				ST_DOT: begin
					term_q <= term_q + 1'b1;
					if (term_q == 3'd5) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_RND;
				ST_RND: begin
					term_q <= '0;
					out_q  <= out_q + 1'b1;
					state_q <= (out_q == 3'd5) ? ST_OUT : ST_DOT;
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			idx_q    <= sensor_index;
			qw_q     <= quat_w;
			qx_q     <= quat_x;
			qy_q     <= quat_y;
			qz_q     <= quat_z;
			ang_q[0] <= ang_vel_world_x;
			ang_q[1] <= ang_vel_world_y;
			ang_q[2] <= ang_vel_world_z;
			lin_q[0] <= lin_vel_world_x;
			lin_q[1] <= lin_vel_world_y;
			lin_q[2] <= lin_vel_world_z;
			per_q    <= period_us;
			en_q     <= (32'(sensor_index) < NUM_SENSORS) && have_q[sensor_index]
				&& (period_us != '0);
		end
		if (state_q == ST_QMUL) p_q[cnt_q] <= prod[31:0];
		if (state_q == ST_MAT) begin
			r_q[0][0] <= p_q[0] + p_q[1] - p_q[2] - p_q[3];
			r_q[0][1] <= (p_q[4] - p_q[5]) <<< 1;
			r_q[0][2] <= (p_q[6] + p_q[7]) <<< 1;
			r_q[1][0] <= (p_q[4] + p_q[5]) <<< 1;
			r_q[1][1] <= p_q[0] - p_q[1] + p_q[2] - p_q[3];
			r_q[1][2] <= (p_q[8] - p_q[9]) <<< 1;
			r_q[2][0] <= (p_q[6] - p_q[7]) <<< 1;
			r_q[2][1] <= (p_q[8] + p_q[9]) <<< 1;
			r_q[2][2] <= p_q[0] - p_q[1] - p_q[2] + p_q[3];
			dacc_q    <= '0;
		end
		if (state_q == ST_AMUL) begin
			mul_q <= prod;
			neg_q <= diff[32];
			if (!en_q) acc_q[comp_q] <= '0;
		end
		if (state_q == ST_AWAIT && div_done) acc_q[comp_q] <= acc_res;
		if (state_q == ST_DOT) begin
			mul_q <= prod;
			mh_q  <= !term_q[0];
		end
		if (mv_q) dacc_q <= dacc_q + term;
		if (state_q == ST_RND) begin
			res_q[out_q] <= sat40(rnd[67:28]);
			dacc_q       <= '0;
		end
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign out_valid        = (state_q == ST_OUT);
	assign orient_x         = qx_q;
	assign orient_y         = qy_q;
	assign orient_z         = qz_q;
	assign orient_w         = qw_q;
	assign body_rate_x      = res_q[0];
	assign body_rate_y      = res_q[1];
	assign body_rate_z      = res_q[2];
	assign specific_force_x = res_q[3];
	assign specific_force_y = res_q[4];
	assign specific_force_z = res_q[5];

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_in_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !out_valid))
		else $error("no work after input transfer");
	a_out_frees_in: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !in_stall)
		else $error("not ready after output transfer");
	a_div_only_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (en_q && per_q != '0))
		else $error("division started without differencing");
endmodule
`default_nettype wire

[src/ibrsf_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module ibrsf_div (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire [ibrsf_pkg::DIV_W-1:0]    dividend,
	input  wire [ibrsf_pkg::PER_W-1:0]    divisor,
	output logic                          done,
	output logic [ibrsf_pkg::DIV_W-1:0]   quotient
);
	import ibrsf_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PER_W-1:0]     dvs_q;
	logic [PER_W:0]       rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic                 done_q;
	logic [PER_W:0]       rem_sh;
	logic [PER_W:0]       rem_sub;
	logic                 take;

	// restoring division, one quotient bit per cycle
	always_comb begin
		rem_sh  = {rem_q[PER_W-1:0], quo_q[DIV_W-1]};
		take    = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub : rem_sh;
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

[tb/imu_body_rate_and_specific_force_checker.sv]
`timescale 1ns / 1ps
module imu_body_rate_and_specific_force_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wr_en,
	input  wire        [21:0] cfg_wr_data,
	input  wire               in_valid,
	input  wire               in_stall,
	input  wire         [1:0] sensor_index,
	input  wire signed [15:0] quat_w,
	input  wire signed [15:0] quat_x,
	input  wire signed [15:0] quat_y,
	input  wire signed [15:0] quat_z,
	input  wire signed [31:0] ang_vel_world_x,
	input  wire signed [31:0] ang_vel_world_y,
	input  wire signed [31:0] ang_vel_world_z,
	input  wire signed [31:0] lin_vel_world_x,
	input  wire signed [31:0] lin_vel_world_y,
	input  wire signed [31:0] lin_vel_world_z,
	input  wire        [19:0] period_us,
	input  wire               out_valid,
	input  wire               out_stall,
	input  wire signed [15:0] orient_x,
	input  wire signed [15:0] orient_y,
	input  wire signed [15:0] orient_z,
	input  wire signed [15:0] orient_w,
	input  wire signed [31:0] body_rate_x,
	input  wire signed [31:0] body_rate_y,
	input  wire signed [31:0] body_rate_z,
	input  wire signed [31:0] specific_force_x,
	input  wire signed [31:0] specific_force_y,
	input  wire signed [31:0] specific_force_z,
	output int                errors,
	output int                outstanding
);
	import ibrsf_pkg::*;

	typedef struct packed {
		logic [15:0] ox, oy, oz, ow;
		logic [31:0] rx, ry, rz;
		logic [31:0] fx, fy, fz;
	} imu_sample_t;

	imu_sample_t expected_samples[$];
	longint prev_vel[NUM_SENSORS][3];
	bit has_prev[NUM_SENSORS];
	logic [GRAV_W-1:0] gravity;

	function automatic logic signed [31:0] clamp32(longint x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// one body-frame component: round(c . v / 2^28), exact, half toward +inf
	function automatic logic signed [31:0] rotate_axis(longint c0, longint c1, longint c2,
			longint v0, longint v1, longint v2);
		logic signed [95:0] a0, a1, a2, b0, b1, b2, s;
		a0 = c0; a1 = c1; a2 = c2;
		b0 = v0; b1 = v1; b2 = v2;
		s = a0 * b0 + a1 * b1 + a2 * b2;
		s = (s + (96'sd1 <<< 27)) >>> 28;
		if (s > 96'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (s < -96'sd2147483648) begin
			return 32'sh80000000;
		end
		return s[31:0];
	endfunction

	function automatic longint accel_of(longint diff, longint unsigned per);
		longint unsigned mag;
		longint unsigned q;
		longint sq;
		mag = (diff < 0 ? -diff : diff);
		mag = mag * 64'd1000000;
		q = (mag + per / 2) / per;
		sq = q;
		return clamp32(diff < 0 ? -sq : sq);
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		imu_sample_t e;
		imu_sample_t g;
		longint w, x, y, z;
		longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
		longint ang[3], lin[3], acc[3];
		int idx;
		if (!arst_n) begin
			expected_samples.delete();
			gravity <= GRAV_RESET;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				has_prev[i] = 0;
				for (int k = 0; k < 3; k++) prev_vel[i][k] = 0;
			end
			errors <= 0;
		end else begin
			if (cfg_wr_en) begin
				gravity <= cfg_wr_data;
			end
			if (out_valid && !out_stall) begin
				g = '{orient_x, orient_y, orient_z, orient_w, body_rate_x, body_rate_y,
					body_rate_z, specific_force_x, specific_force_y, specific_force_z};
				if (expected_samples.size() == 0) begin
					$display("unexpected result transfer at %0t", $time);
					errors++;
				end else begin
					e = expected_samples.pop_front();
					if (g.ox !== e.ox) report("orient_x", 32'(g.ox), 32'(e.ox));
					if (g.oy !== e.oy) report("orient_y", 32'(g.oy), 32'(e.oy));
					if (g.oz !== e.oz) report("orient_z", 32'(g.oz), 32'(e.oz));
					if (g.ow !== e.ow) report("orient_w", 32'(g.ow), 32'(e.ow));
					if (g.rx !== e.rx) report("body_rate_x", g.rx, e.rx);
					if (g.ry !== e.ry) report("body_rate_y", g.ry, e.ry);
					if (g.rz !== e.rz) report("body_rate_z", g.rz, e.rz);
					if (g.fx !== e.fx) report("specific_force_x", g.fx, e.fx);
					if (g.fy !== e.fy) report("specific_force_y", g.fy, e.fy);
					if (g.fz !== e.fz) report("specific_force_z", g.fz, e.fz);
				end
			end
			if (in_valid && !in_stall) begin
				idx = sensor_index;
				w = quat_w; x = quat_x; y = quat_y; z = quat_z;
				ang[0] = ang_vel_world_x; ang[1] = ang_vel_world_y; ang[2] = ang_vel_world_z;
				lin[0] = lin_vel_world_x; lin[1] = lin_vel_world_y; lin[2] = lin_vel_world_z;
				r00 = w * w + x * x - y * y - z * z;
				r01 = 2 * (x * y - w * z);
				r02 = 2 * (x * z + w * y);
				r10 = 2 * (x * y + w * z);
				r11 = w * w - x * x + y * y - z * z;
				r12 = 2 * (y * z - w * x);
				r20 = 2 * (x * z - w * y);
				r21 = 2 * (y * z + w * x);
				r22 = w * w - x * x - y * y + z * z;
				for (int k = 0; k < 3; k++) begin
					acc[k] = 0;
					if (idx < NUM_SENSORS && has_prev[idx] && period_us != 0)
						acc[k] = accel_of(lin[k] - prev_vel[idx][k], longint'(period_us));
				end
				if (idx < NUM_SENSORS) begin
					for (int k = 0; k < 3; k++) prev_vel[idx][k] = lin[k];
					has_prev[idx] = 1;
				end
				acc[2] = acc[2] + longint'(gravity);
				e.ox = quat_x; e.oy = quat_y; e.oz = quat_z; e.ow = quat_w;
				e.rx = rotate_axis(r00, r10, r20, ang[0], ang[1], ang[2]);
				e.ry = rotate_axis(r01, r11, r21, ang[0], ang[1], ang[2]);
				e.rz = rotate_axis(r02, r12, r22, ang[0], ang[1], ang[2]);
				e.fx = rotate_axis(r00, r10, r20, acc[0], acc[1], acc[2]);
				e.fy = rotate_axis(r01, r11, r21, acc[0], acc[1], acc[2]);
				e.fz = rotate_axis(r02, r12, r22, acc[0], acc[1], acc[2]);
				expected_samples = {expected_samples, e};
			end
		end
	end

	assign outstanding = expected_samples.size();
endmodule

[tb/imu_body_rate_and_specific_force_top_tb.sv]
`timescale 1ns / 1ps
module imu_body_rate_and_specific_force_top_tb;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [21:0] cfg_wr_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] sensor_index;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	logic signed [31:0] ang_x, ang_y, ang_z;
	logic signed [31:0] lin_x, lin_y, lin_z;
	logic [19:0] period_us;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] orient_x, orient_y, orient_z, orient_w;
	logic signed [31:0] body_rate_x, body_rate_y, body_rate_z;
	logic signed [31:0] specific_force_x, specific_force_y, specific_force_z;
	int errors;
	int outstanding;
	bit quiet;
	bit hold_req;
	int samples_sent;
	int cycles;

	imu_body_rate_and_specific_force_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .sensor_index(sensor_index),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.ang_vel_world_x(ang_x), .ang_vel_world_y(ang_y), .ang_vel_world_z(ang_z),
		.lin_vel_world_x(lin_x), .lin_vel_world_y(lin_y), .lin_vel_world_z(lin_z),
		.period_us(period_us), .out_valid(out_valid), .out_stall(out_stall),
		.orient_x(orient_x), .orient_y(orient_y), .orient_z(orient_z), .orient_w(orient_w),
		.body_rate_x(body_rate_x), .body_rate_y(body_rate_y), .body_rate_z(body_rate_z),
		.specific_force_x(specific_force_x), .specific_force_y(specific_force_y),
		.specific_force_z(specific_force_z)
	);

	imu_body_rate_and_specific_force_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .sensor_index(sensor_index),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.ang_vel_world_x(ang_x), .ang_vel_world_y(ang_y), .ang_vel_world_z(ang_z),
		.lin_vel_world_x(lin_x), .lin_vel_world_y(lin_y), .lin_vel_world_z(lin_z),
		.period_us(period_us), .out_valid(out_valid), .out_stall(out_stall),
		.orient_x(orient_x), .orient_y(orient_y), .orient_z(orient_z), .orient_w(orient_w),
		.body_rate_x(body_rate_x), .body_rate_y(body_rate_y), .body_rate_z(body_rate_z),
		.specific_force_x(specific_force_x), .specific_force_y(specific_force_y),
		.specific_force_z(specific_force_z), .errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("imu_body_rate_and_specific_force_top_tb: done, errors");
				$finish;
			end
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		int burst;
		burst = 0;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1;
				repeat (700) @(negedge clk);
				hold_req = 0;
				out_stall = 0;
			end else if (quiet) begin
				out_stall = 0;
			end else if (burst > 0) begin
				out_stall = 1;
				burst--;
			end else if ($urandom_range(0, 5) == 0) begin
				out_stall = 1;
				burst = $urandom_range(0, 16);
			end else begin
				out_stall = 0;
			end
		end
	end

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
			1: return $signed($urandom_range(0, 65535)) - 32'sd32768;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic signed [15:0] rand_quat();
		return 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
	endfunction

	task automatic send(logic [1:0] idx, logic signed [15:0] w, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z, logic signed [31:0] ax,
			logic signed [31:0] ay, logic signed [31:0] az, logic signed [31:0] lx,
			logic signed [31:0] ly, logic signed [31:0] lz, logic [19:0] per);
		bit took;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		sensor_index = idx;
		quat_w = w; quat_x = x; quat_y = y; quat_z = z;
		ang_x = ax; ang_y = ay; ang_z = az;
		lin_x = lx; lin_y = ly; lin_z = lz;
		period_us = per;
		in_valid = 1;
		do begin
			took = !in_stall;
			@(negedge clk);
		end while (!took);
		in_valid = 0;
		samples_sent++;
	endtask

	task automatic send_random();
		logic [19:0] per;
		logic signed [31:0] lx, ly, lz;
		case ($urandom_range(0, 7))
			0: per = 0;
			1: per = 20'($urandom_range(1, 20));
			2: per = 20'($urandom_range(1000001, 20'hFFFFF));
			3: per = 20'($urandom_range(0, 1000000));
			default: per = 20'($urandom_range(500, 20000));
		endcase
		// mostly slowly varying velocity so the acceleration stays in range
		if ($urandom_range(0, 3) != 0) begin
			lx = lin_x + $signed($urandom_range(0, 4096)) - 2048;
			ly = lin_y + $signed($urandom_range(0, 4096)) - 2048;
			lz = lin_z + $signed($urandom_range(0, 4096)) - 2048;
		end else begin
			lx = rand_word(); ly = rand_word(); lz = rand_word();
		end
		send(2'($urandom_range(0, 3)), rand_quat(), rand_quat(), rand_quat(), rand_quat(),
			rand_word(), rand_word(), rand_word(), lx, ly, lz, per);
	endtask

	task automatic drain_and_write(logic [21:0] g);
		while (outstanding != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_wr_data = g;
		cfg_wr_en = 1;
		@(negedge clk);
		cfg_wr_en = 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		in_valid = 0;
		sensor_index = 0;
		quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
		ang_x = 0; ang_y = 0; ang_z = 0;
		lin_x = 0; lin_y = 0; lin_z = 0;
		period_us = 0;
		quiet = 0;
		hold_req = 0;
		samples_sent = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// identity, first sample per sensor, then differencing and zero period
		send(0, 16384, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, 65536, 0, 0, 1000);
		send(0, 16384, 0, 0, 0, 0, 0, 65536, 131072, 0, 0, 1000);
		send(0, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(1, -16384, 0, 0, 0, 65536, 65536, 65536, 32'sh7fffffff, 32'sh80000000, 5, 1);
		send(1, 0, 16384, 0, 0, 65536, 0, 0, 32'sh80000000, 32'sh7fffffff, -5, 1);
		send(2, 0, 0, 16384, 0, 1, -1, 2, 100, 200, 300, 20'hFFFFF);
		send(2, 0, 0, 0, 16384, 1, -1, 2, 400, -200, 30, 20'hFFFFF);
		send(3, 16384, 16384, 16384, 16384, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			0, 0, 0, 1000000);
		send(3, -16384, -16384, -16384, -16384, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 3, -3, 1, 1000000);
		send(3, 0, 0, 0, 0, 12345, 6789, -4242, 7, 7, 7, 2);
		send(0, 11585, 11585, 0, 0, 65536, 65536, 0, 65536, 65536, 65536, 3);
		send(1, 8192, -8192, 8192, -8192, -65536, 32768, 98304, 0, 0, 0, 1);
		send(2, -1, 1, -1, 1, -1, -1, -1, -1, -1, -1, 2);
		send(2, 16383, -16383, 21, -21, 32'sh55555555, 32'shaaaaaaaa, 0, 32'sh55555555,
			32'shaaaaaaaa, 0, 20'h55555);
		send(2, 10922, -10922, 10922, -10922, 32'shaaaaaaaa, 32'sh55555555, 1, 32'shaaaaaaaa,
			32'sh55555555, 1, 20'haaaaa);

		drain_and_write(0);
		repeat (150) send_random();
		// long receiver hold-off while samples keep coming
		hold_req = 1;
		repeat (30) send_random();
		drain_and_write(22'd2097152);
		repeat (150) send_random();
		drain_and_write(22'($urandom_range(1, 2097151)));
		repeat (150) send_random();
		drain_and_write(22'd642908);
		quiet = 1;
		repeat (150) send_random();

		while (outstanding != 0) @(negedge clk);
		repeat (500) @(negedge clk);
		$display("sent %0d samples over four sensors at five gravity settings,", samples_sent);
		$display("with stall bursts, a long result hold-off and a quiet final stretch");
		if (errors == 0) begin
			$display("imu_body_rate_and_specific_force_top_tb: done, clean");
		end else begin
			$display("imu_body_rate_and_specific_force_top_tb: done, errors");
		end
		$finish;
	end
endmodule
